// File: src/fsac_pkg.sv
// ----------------------------------------------------------------------------
// fsac_pkg
// Shared types and constants for the format string argument counter.
// ----------------------------------------------------------------------------
package fsac_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CH_WIDTH    = 8;
    localparam int ARG_WIDTH   = 16;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [CH_WIDTH-1:0]    ch_t;
    typedef logic [ARG_WIDTH-1:0]   arg_t;

    localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam arg_t   ARG_MAX   = {ARG_WIDTH{1'b1}};

    // Parse phases of a conversion specification
    typedef enum logic [3:0] {
        PH_TEXT      = 4'd0,
        PH_AFTER_PCT = 4'd1,
        PH_FLAGS     = 4'd2,
        PH_WIDTH     = 4'd3,
        PH_DOT       = 4'd4,
        PH_PREC0     = 4'd5,
        PH_PREC      = 4'd6,
        PH_LENGTH    = 4'd7,
        PH_SECOND_H  = 4'd8,
        PH_SECOND_L  = 4'd9,
        PH_CONV      = 4'd10
    } phase_t;

    localparam ch_t CH_NUL   = 8'h00;
    localparam ch_t CH_PCT   = 8'h25; // '%'
    localparam ch_t CH_STAR  = 8'h2A; // '*'
    localparam ch_t CH_DOT   = 8'h2E; // '.'
    localparam ch_t CH_MINUS = 8'h2D; // '-'
    localparam ch_t CH_PLUS  = 8'h2B; // '+'
    localparam ch_t CH_SPACE = 8'h20; // ' '
    localparam ch_t CH_HASH  = 8'h23; // '#'
    localparam ch_t CH_ZERO  = 8'h30; // '0'
    localparam ch_t CH_NINE  = 8'h39; // '9'
    localparam ch_t CH_H     = 8'h68; // 'h'
    localparam ch_t CH_L     = 8'h6C; // 'l'
    localparam ch_t CH_J     = 8'h6A; // 'j'
    localparam ch_t CH_Z     = 8'h7A; // 'z'
    localparam ch_t CH_T     = 8'h74; // 't'
    localparam ch_t CH_UPPER_L = 8'h4C; // 'L'

endpackage

// File: src/format_string_arg_counter.sv
// ----------------------------------------------------------------------------
// format_string_arg_counter
// Streaming printf-style format string parser counting consumed arguments.
// ----------------------------------------------------------------------------
// A terminator item passes through the input register and then the result
//   register, which holds its count on the m_ signals until it is taken.
// Throughput: one byte per cycle while s_ready is high; the parse decision is a short fall-through
//   chain over the phases plus one saturating increment.
// s_ready drops only while a terminator waits behind an untaken result.
// Reset (aresetn low, synchronous): phase to plain text, count to zero,
//   both item registers empty.
// ----------------------------------------------------------------------------
module format_string_arg_counter (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fsac_pkg::ch_t         s_ch,
    output logic                  m_valid,
    input  logic                  m_ready,
    output fsac_pkg::arg_t        m_num_args
);

    // Input register stage
    logic                  in_valid_reg;
    fsac_pkg::ch_t         ch_reg;

    // Parse state
    fsac_pkg::phase_t      phase_reg, phase_next;
    fsac_pkg::count_t      count_reg, count_next;

    // Result register
    logic                  out_valid_reg;
    fsac_pkg::arg_t        arg_reg, arg_next;

    logic                  is_term;
    logic                  proceed;
    logic                  bump;
    logic [32:0]           count_wide;

    assign is_term = (ch_reg == fsac_pkg::CH_NUL);
    // The held item moves on unless it is a terminator and the result slot is full and not being taken
    assign proceed = in_valid_reg && !(is_term && out_valid_reg && !m_ready);
    assign s_ready = !in_valid_reg || proceed;

    assign m_valid    = out_valid_reg;
    assign m_num_args = arg_reg;

    // Phase walk: a byte that does not fit a phase falls into a later one
    // within the same cycle. Fall-through steps only ever move forward through the
    // list, so an ordered chain of tests covers every path.
    always_comb begin
        fsac_pkg::phase_t ph;
        logic             done;
        ph   = phase_reg;
        done = 1'b0;
        bump = 1'b0;

        if (ph == fsac_pkg::PH_AFTER_PCT) begin
            if (ch_reg == fsac_pkg::CH_PCT) begin
                ph   = fsac_pkg::PH_TEXT;   // doubled percent
                done = 1'b1;
            end else begin
                ph = fsac_pkg::PH_FLAGS;
            end
        end
        if (!done && ph == fsac_pkg::PH_FLAGS) begin
            if (ch_reg inside {fsac_pkg::CH_MINUS, fsac_pkg::CH_PLUS, fsac_pkg::CH_SPACE,
                               fsac_pkg::CH_HASH, fsac_pkg::CH_ZERO}) begin
                done = 1'b1;
            end else if (ch_reg == fsac_pkg::CH_STAR) begin
                bump = 1'b1;                 // star width
                ph   = fsac_pkg::PH_DOT;
                done = 1'b1;
            end else if (ch_reg inside {[fsac_pkg::CH_ZERO:fsac_pkg::CH_NINE]}) begin
                ph   = fsac_pkg::PH_WIDTH;
                done = 1'b1;
            end else begin
                ph = fsac_pkg::PH_DOT;
            end
        end
        if (!done && ph == fsac_pkg::PH_WIDTH) begin
            if (ch_reg inside {[fsac_pkg::CH_ZERO:fsac_pkg::CH_NINE]}) begin
                done = 1'b1;
            end else begin
                ph = fsac_pkg::PH_DOT;
            end
        end
        if (!done && ph == fsac_pkg::PH_DOT) begin
            if (ch_reg == fsac_pkg::CH_DOT) begin
                ph   = fsac_pkg::PH_PREC0;
                done = 1'b1;
            end else begin
                ph = fsac_pkg::PH_LENGTH;
            end
        end
        if (!done && ph == fsac_pkg::PH_PREC0) begin
            if (ch_reg == fsac_pkg::CH_STAR) begin
                bump = 1'b1;                 // star precision
                ph   = fsac_pkg::PH_LENGTH;
                done = 1'b1;
            end else if (ch_reg inside {[fsac_pkg::CH_ZERO:fsac_pkg::CH_NINE]}) begin
                ph   = fsac_pkg::PH_PREC;
                done = 1'b1;
            end else begin
                ph = fsac_pkg::PH_LENGTH;
            end
        end
        if (!done && ph == fsac_pkg::PH_PREC) begin
            if (ch_reg inside {[fsac_pkg::CH_ZERO:fsac_pkg::CH_NINE]}) begin
                done = 1'b1;
            end else begin
                ph = fsac_pkg::PH_LENGTH;
            end
        end
        if (!done && ph == fsac_pkg::PH_LENGTH) begin
            if (ch_reg == fsac_pkg::CH_H) begin
                ph   = fsac_pkg::PH_SECOND_H;
                done = 1'b1;
            end else if (ch_reg == fsac_pkg::CH_L) begin
                ph   = fsac_pkg::PH_SECOND_L;
                done = 1'b1;
            end else if (ch_reg inside {fsac_pkg::CH_J, fsac_pkg::CH_Z, fsac_pkg::CH_T,
                                        fsac_pkg::CH_UPPER_L}) begin
                ph   = fsac_pkg::PH_CONV;
                done = 1'b1;
            end else begin
                ph = fsac_pkg::PH_CONV;
            end
        end
        if (!done && ph == fsac_pkg::PH_SECOND_H) begin
            ph   = fsac_pkg::PH_CONV;
            done = (ch_reg == fsac_pkg::CH_H);
        end
        if (!done && ph == fsac_pkg::PH_SECOND_L) begin
            ph   = fsac_pkg::PH_CONV;
            done = (ch_reg == fsac_pkg::CH_L);
        end
        if (!done && ph == fsac_pkg::PH_CONV) begin
            bump = 1'b1;                     // conversion character
            ph   = fsac_pkg::PH_TEXT;
            done = 1'b1;
        end
        if (!done) begin
            // plain text, and any unused phase code
            if (ch_reg == fsac_pkg::CH_PCT) begin
                ph = fsac_pkg::PH_AFTER_PCT;
            end else begin
                ph = fsac_pkg::PH_TEXT;
            end
        end

        phase_next = ph;
        count_next = count_reg;
        if (is_term) begin
            phase_next = fsac_pkg::PH_TEXT;
            count_next = '0;
        end else if (bump && count_reg != fsac_pkg::COUNT_MAX) begin
            count_next = count_reg + fsac_pkg::count_t'(1);
        end
    end

    // Saturate the running count into the result field
    always_comb begin
        count_wide = 33'(count_reg);
        if (count_wide > 33'(fsac_pkg::ARG_MAX)) begin
            arg_next = fsac_pkg::ARG_MAX;
        end else begin
            arg_next = count_wide[fsac_pkg::ARG_WIDTH-1:0];
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg <= s_ch;
        end
    end

    // Parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= fsac_pkg::PH_TEXT;
            count_reg <= '0;
        end else if (proceed) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proceed && is_term) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed && is_term) begin
            arg_reg <= arg_next;
        end
    end

`ifndef SYNTH
    // Input side only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (out_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    // A terminator always produces a result next cycle
    a_term_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (proceed && is_term) |=> out_valid_reg)
        else $error("terminator gave no result");

    // A terminator clears the parse state
    a_term_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (proceed && is_term) |=> (phase_reg == fsac_pkg::PH_TEXT && count_reg == '0))
        else $error("terminator did not clear state");

    // Between terminators the count never falls and grows by at most one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (proceed && !is_term) |=>
            (count_reg == $past(count_reg) ||
             count_reg == $past(count_reg) + fsac_pkg::count_t'(1)))
        else $error("running count moved by more than one");
`endif

endmodule
